### design/plr_pkg.sv
// Package: payload structs and configuration register codes of the polyline resampler.
`timescale 1ns / 1ps

package plr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TOLERANCE = 2'd1;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               starts_path;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               is_original;
        logic               truncated;
        logic               last;
    } t_out;

endpackage

### design/plr_divider.sv
// Iterative 64/32 restoring divider, one quotient bit per cycle (quotient fits 32 bits).
`timescale 1ns / 1ps

module plr_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_quo <= i_dividend[31:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### design/polyline_linear_resampler_core.sv
// Top level: sequencer, configuration registers and output register of the polyline resampler.
`timescale 1ns / 1ps

// Each input point yields the generated points x = prev_x + k*step that lie
// short of the new x (minus the end tolerance, at most MAX_NEW of them), then the
// point itself with last set. Each generated point waits on the serial
// 32-step divider that scales dy, and o_in_stall stays high until the
// original point is loaded into the output register. Output stalls hold
// the sequencer in S_EMIT and S_ORIG.

module polyline_linear_resampler_core #(
    parameter int MAX_NEW   = 63,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  plr_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output plr_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [plr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [plr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import plr_pkg::*;

    localparam int KW = $clog2(MAX_NEW + 2);
    localparam int LW = 31 + KW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_LIMIT = 9'b000000100,
        S_TRUNC = 9'b000001000,
        S_NEXT  = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_ORIG  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [30:0]        r_step;
    logic [15:0]        r_tol;
    logic [31:0]        r_prev_x;
    logic [31:0]        r_prev_y;
    logic               r_have_prev;
    t_in                r_in;
    logic [31:0]        r_d;
    logic [32:0]        r_dy;
    logic               r_gen;
    logic [31:0]        r_e;
    logic [31:0]        r_ady;
    logic               r_neg;
    logic [LW-1:0]      r_lim;
    logic               r_trunc;
    logic [32:0]        r_t;
    logic [KW-1:0]      r_k;
    logic [63:0]        r_prod;
    logic               r_div_go;
    logic               r_out_valid;
    t_out               r_out;

    logic [30:0]        w_step;
    logic               w_out_free;
    logic               w_div_done;
    logic [31:0]        w_quot;
    logic               w_more;

    assign w_step     = (r_step == 31'd0) ? 31'd1 : r_step;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_more     = r_gen && (r_k <= KW'(MAX_NEW)) && (r_t <= {1'b0, r_e});

    plr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .i_divisor  (r_d[31:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP;
            S_PREP:  n_state = S_LIMIT;
            S_LIMIT: n_state = S_TRUNC;
            S_TRUNC: n_state = S_NEXT;
            S_NEXT:  n_state = w_more ? S_MUL : S_ORIG;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_EMIT;
            S_EMIT:  if (w_out_free) n_state = S_NEXT;
            S_ORIG:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 31'(64'd1 << FRAC_BITS);
            r_tol       <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_MUL);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP:          r_step <= i_cfg_data[30:0];
                    CFG_END_TOLERANCE: r_tol  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if ((r_state == S_EMIT || r_state == S_ORIG) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ORIG && w_out_free) begin
                r_prev_x    <= r_in.point_x;
                r_prev_y    <= r_in.point_y;
                r_have_prev <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_in <= i_in;
            end
            S_PREP: begin
                r_d   <= r_in.point_x - r_prev_x;
                r_dy  <= {r_in.point_y[31], r_in.point_y} - {r_prev_y[31], r_prev_y};
                r_gen <= !r_in.starts_path && r_have_prev &&
                         ($signed(r_in.point_x) > $signed(r_prev_x));
            end
            S_LIMIT: begin
                if (r_tol == 16'd0) begin
                    r_e <= r_d[31:0] - 32'd1;
                end else if (r_d[31:0] > {16'd0, r_tol}) begin
                    r_e <= r_d[31:0] - {16'd0, r_tol};
                end else begin
                    r_e <= '0;
                end
                r_neg <= r_dy[32];
                r_ady <= r_dy[32] ? 32'(-r_dy) : r_dy[31:0];
                r_lim <= LW'(w_step) * LW'(MAX_NEW + 1);
            end
            S_TRUNC: begin
                r_trunc <= r_gen && ({(LW-32)'(0), r_e} >= r_lim);
                r_t     <= {2'b00, w_step};
                r_k     <= KW'(1);
            end
            S_MUL: begin
                r_prod <= 64'(r_ady) * 64'(r_t[31:0]);
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out.out_x       <= r_prev_x + r_t[31:0];
                    r_out.out_y       <= r_neg ? r_prev_y - w_quot : r_prev_y + w_quot;
                    r_out.is_original <= 1'b0;
                    r_out.truncated   <= r_trunc;
                    r_out.last        <= 1'b0;
                    r_t               <= r_t + {2'b00, w_step};
                    r_k               <= r_k + KW'(1);
                end
            end
            S_ORIG: begin
                if (w_out_free) begin
                    r_out.out_x       <= r_in.point_x;
                    r_out.out_y       <= r_in.point_y;
                    r_out.is_original <= 1'b1;
                    r_out.truncated   <= r_trunc;
                    r_out.last        <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### design/plr_checker.sv
// Port-level checker for the polyline resampler, bound to the top level.
`timescale 1ns / 1ps

module plr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  plr_pkg::t_out                       o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous item still in work");

    a_last_is_orig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last |-> o_out.is_original)
        else $error("last beat is not the original point");

    a_idle_only_orig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_stall |-> o_out.last)
        else $error("generated point pending while ready for input");

endmodule

bind polyline_linear_resampler_core plr_checker u_plr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

### tb/polyline_linear_resampler_core_tb.sv
// Testbench: random and directed points through the polyline resampler, checked against a predictor.
`timescale 1ns / 1ps

module polyline_linear_resampler_core_tb;

    import plr_pkg::*;

    localparam int     MAX_NEW = 63;
    localparam int     SETTLE  = 10;
    localparam longint XMIN    = -64'sd2147483648;
    localparam longint XMAX    = 64'sd2147483647;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    t_in                   in_beat   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out                  out_beat;

    // predictor copy of registers and state
    bit [30:0] step_reg = 31'h0001_0000;
    bit [15:0] tol_reg  = 16'h0000;
    longint    prv_x    = 0;
    longint    prv_y    = 0;
    bit        prv_ok   = 1'b0;

    t_in    pending_pts[$];
    t_out   want_pts[$];
    int     errors      = 0;
    bit     idle_on     = 1'b1;
    bit     in_took     = 1'b0;
    int     in_gap      = 0;
    int     ostall_left = 0;
    int     ostall_n;
    longint cur_x       = 0;
    longint cur_y       = 0;
    t_out   head;

    polyline_linear_resampler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // expected output points for one accepted input point
    function automatic void resample_point(input t_in pt);
        longint    nx, ny, dy, yv;
        bit [63:0] d, stp, cand, keep, m, ady, t, q, k;
        bit        trunc;
        t_out      r;
        nx    = $signed(pt.point_x);
        ny    = $signed(pt.point_y);
        trunc = 1'b0;
        if (!pt.starts_path && prv_ok && nx > prv_x) begin
            d    = nx - prv_x;
            stp  = (step_reg == 0) ? 64'd1 : 64'(step_reg);
            cand = (d - 64'd1) / stp;
            keep = (d > 64'(tol_reg)) ? (d - 64'(tol_reg)) / stp : 64'd0;
            m    = (keep < cand) ? keep : cand;
            dy   = ny - prv_y;
            ady  = (dy < 0) ? -dy : dy;
            if (m > MAX_NEW) begin
                m     = MAX_NEW;
                trunc = 1'b1;
            end
            for (k = 1; k <= m; k++) begin
                t  = k * stp;
                q  = (ady * t) / d;
                yv = (dy < 0) ? prv_y - longint'(q) : prv_y + longint'(q);
                r.out_x       = 32'(prv_x + longint'(t));
                r.out_y       = 32'(yv);
                r.is_original = 1'b0;
                r.truncated   = trunc;
                r.last        = 1'b0;
                want_pts.insert(want_pts.size(), r);
            end
        end
        r.out_x       = pt.point_x;
        r.out_y       = pt.point_y;
        r.is_original = 1'b1;
        r.truncated   = trunc;
        r.last        = 1'b1;
        want_pts.insert(want_pts.size(), r);
        prv_x  = nx;
        prv_y  = ny;
        prv_ok = 1'b1;
    endfunction

    function automatic void queue_point(input longint x, input longint y, input bit sp);
        t_in p;
        p.point_x     = x[31:0];
        p.point_y     = y[31:0];
        p.starts_path = sp;
        cur_x         = $signed(p.point_x);
        cur_y         = $signed(p.point_y);
        pending_pts.insert(pending_pts.size(), p);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (errors < 40)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_STEP) step_reg = data[30:0];
        else if (idx == CFG_END_TOLERANCE) tol_reg = data[15:0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_pts.size() != 0 || in_valid || want_pts.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mostly rising paths with a few intervals per point, some noise
    task automatic fill_random(input int n);
        longint eff, dx, nx, ny;
        int     roll, k;
        eff = (step_reg == 0) ? 64'sd1 : longint'(step_reg);
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 1) != 0) ny = $signed($urandom);
            else ny = cur_y + $urandom_range(0, 4000) - 2000;
            if (roll < 6) begin
                queue_point($signed($urandom), ny, $urandom_range(0, 1));
            end else if (roll < 11) begin
                nx = XMIN + $urandom_range(0, 32'h8000_0000);
                queue_point(nx, ny, 1'b1);
            end else if (roll < 17) begin
                nx = cur_x - longint'($urandom_range(0, 1000));
                if (nx < XMIN) nx = XMIN;
                queue_point(nx, ny, 1'b0);
            end else begin
                k = ($urandom_range(0, 99) < 3) ? $urandom_range(60, 68) : $urandom_range(0, 3);
                case ($urandom_range(0, 3))
                    0: dx = 0;
                    1: dx = longint'($urandom_range(0, tol_reg + 1)) % eff;
                    default: dx = $urandom_range(0, eff - 1);
                endcase
                dx = k * eff + dx;
                nx = cur_x + dx;
                if (nx > XMAX)
                    queue_point(XMIN + $urandom_range(0, 32'h0010_0000), ny, 1'b1);
                else
                    queue_point(nx, ny, $urandom_range(0, 99) < 4);
            end
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_took)) begin
            if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (pending_pts.size() != 0) begin
                in_valid <= 1'b1;
                in_beat  <= pending_pts.pop_front();
                in_gap   <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        if (ostall_left != 0) begin
            out_stall   <= 1'b1;
            ostall_left <= ostall_left - 1;
        end else begin
            ostall_n     = pick_gap();
            out_stall   <= (ostall_n != 0);
            ostall_left <= (ostall_n != 0) ? ostall_n - 1 : 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) resample_point(in_beat);
            if (o_out_valid && !out_stall) begin
                if (want_pts.size() == 0) begin
                    if (errors < 40)
                        $display("%0t ns: unexpected output beat, expected none, got x=%h y=%h",
                                 $time, out_beat.out_x, out_beat.out_y);
                    errors++;
                end else begin
                    head = want_pts.pop_front();
                    check_field("out_x", head.out_x, out_beat.out_x);
                    check_field("out_y", head.out_y, out_beat.out_y);
                    check_field("is_original", head.is_original, out_beat.is_original);
                    check_field("truncated", head.truncated, out_beat.truncated);
                    check_field("last", head.last, out_beat.last);
                end
            end
        end
    end

    initial begin
        logic [31:0] s, t;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first point, plain interval, flat and falling x, path start
        queue_point(0, 0, 1'b0);
        queue_point(3 << 16, 6 << 16, 1'b0);
        queue_point(3 << 16, -5, 1'b0);
        queue_point(1 << 16, 7, 1'b0);
        queue_point(9 << 16, 9, 1'b1);
        // full-range extremes, overflowing interval
        queue_point(XMIN, XMIN, 1'b1);
        queue_point(XMAX, XMAX, 1'b0);
        queue_point(XMIN, XMAX, 1'b0);
        // exactly MAX_NEW candidates, then one more
        queue_point(XMIN + 64 * 65536, XMIN, 1'b0);
        queue_point(XMIN + 128 * 65536 + 1, 0, 1'b0);
        queue_point(XMIN + 133 * 65536 + 8, XMAX, 1'b0);
        wait_idle();

        // tolerance tail
        write_reg(CFG_END_TOLERANCE, 32'h0000_8000);
        queue_point(0, 0, 1'b1);
        queue_point(32'h0003_4000, 100, 1'b0);
        queue_point(32'h0003_8000, -100, 1'b0);
        queue_point(32'h0003_8000 + 64 * 65536 + 32'h7FFF, 12345, 1'b0);
        wait_idle();

        // zero step behaves as one LSB; upper data bits are dropped
        write_reg(CFG_STEP, 32'h8000_0000);
        write_reg(CFG_END_TOLERANCE, 32'hFFFF_0002);
        queue_point(0, 0, 1'b1);
        queue_point(5, 1000, 1'b0);
        wait_idle();

        // largest step and tolerance, writes to unused indexes
        write_reg(CFG_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_END_TOLERANCE, 32'h0000_FFFF);
        write_reg(CFG_UNUSED_2, $urandom);
        write_reg(CFG_UNUSED_3, $urandom);
        queue_point(XMIN, 0, 1'b1);
        queue_point(XMAX, -1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin s = 32'h0001_0000; t = 32'h0000_0000; end
                1: begin s = 32'h0001_0000; t = 32'h0000_FFFF; end
                2: begin s = 32'h0000_0001; t = 32'h0000_0000; end
                3: begin s = $urandom; t = $urandom; end
                4: begin s = 32'h7FFF_FFFF; t = $urandom_range(0, 65535); end
                default: begin
                    s = $urandom_range(1, 32'h0004_0000) | ($urandom_range(0, 1) << 31);
                    t = $urandom;
                end
            endcase
            idle_on = (ph != 2);
            write_reg(CFG_STEP, s);
            write_reg(CFG_END_TOLERANCE, t);
            write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_2 : CFG_UNUSED_3, $urandom);
            fill_random(69);
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0 && want_pts.size() == 0) begin
            $display("polyline_linear_resampler_core_tb passed");
        end else begin
            $display("polyline_linear_resampler_core_tb failed");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("polyline_linear_resampler_core_tb failed");
        $finish;
    end

endmodule
